// ----- hdl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Item and result layouts, the internal command format passed from the
// front end to the execution engine, and default geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int DEF_COLUMNS     = 80;
	localparam int DEF_ROWS        = 25;
	localparam int DEF_QUEUE_DEPTH = 2;
	localparam int CURSOR_W        = 11;
	localparam int WIDE_W          = 16;

	localparam logic [7:0] ATTR_RESET   = 8'd15;
	localparam logic [7:0] BLANK_CHAR   = 8'd32;
	localparam logic [7:0] NEWLINE_CHAR = 8'd10;

	localparam logic [2:0] KIND_PUT       = 3'd0;
	localparam logic [2:0] KIND_BACKSPACE = 3'd1;
	localparam logic [2:0] KIND_CLEAR     = 3'd2;
	localparam logic [2:0] KIND_SET_POS   = 3'd3;
	localparam logic [2:0] KIND_READ      = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  char_code;
		logic [7:0]  column;
		logic [7:0]  row_index;
		logic [10:0] cell_index;
	} item_t;

	typedef struct packed {
		logic [10:0] cursor;
		logic        position_error;
		logic [7:0]  read_char;
		logic [7:0]  read_attr;
	} result_t;

	typedef enum logic [3:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_CLEAR,
		OP_SET_POS,
		OP_SET_POS_ERR,
		OP_READ,
		OP_READ_OOR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  char_code;
		logic [7:0]  column;
		logic [7:0]  row_index;
		logic [10:0] cell_index;
	} cmd_t;

endpackage

// ----- hdl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/tcw_queue.sv -----
// ----------------------------------------------------------------------------
// tcw_queue: small register queue
// First-in first-out store of a few entries with full and empty flags.
// ----------------------------------------------------------------------------
module tcw_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front: item intake and classification
// Accepts items, sorts them into engine commands and checks positions and
// cell addresses against the screen geometry.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item,
	output logic  full,
	input  logic  busy,
	output logic  cmd_push,
	output cmd_t  cmd,
	input  logic  cmd_full
);

	localparam int CELL_COUNT = COLUMNS * ROWS;

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;
	op_t  op;

	assign full     = busy || (valid_s1 && cmd_full);
	assign accept   = push && !full;
	assign cmd_push = valid_s1;
	assign cmd      = cmd_s1;

	always_comb begin
		case (item.kind)
			KIND_PUT: begin
				op = (item.char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
			end
			KIND_BACKSPACE: begin
				op = OP_BACKSPACE;
			end
			KIND_CLEAR: begin
				op = OP_CLEAR;
			end
			KIND_SET_POS: begin
				if (item.column >= 8'(COLUMNS) || item.row_index >= 8'(ROWS)) begin
					op = OP_SET_POS_ERR;
				end else begin
					op = OP_SET_POS;
				end
			end
			KIND_READ: begin
				if (WIDE_W'(item.cell_index) < WIDE_W'(CELL_COUNT)) begin
					op = OP_READ;
				end else begin
					op = OP_READ_OOR;
				end
			end
			default: begin
				op = OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op         <= op;
			cmd_s1.char_code  <= item.char_code;
			cmd_s1.column     <= item.column;
			cmd_s1.row_index  <= item.row_index;
			cmd_s1.cell_index <= item.cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!cmd_full) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

// ----- hdl/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back: console execution engine
// Owns the cell store, the cursor and the attribute register. Runs the
// clearing pass after reset, writes cells, scrolls, clears and reads cells.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	output logic       busy,
	input  logic       cmd_empty,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	input  logic       res_full,
	output logic       res_push,
	output result_t    res
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int BOTTOM     = COLUMNS * (ROWS - 1);
	localparam int CW         = $clog2(CELL_COUNT);
	localparam int COLW       = $clog2(COLUMNS);

	typedef enum logic [5:0] {
		ST_INIT      = 6'b000001,
		ST_IDLE      = 6'b000010,
		ST_READ_WAIT = 6'b000100,
		ST_COPY      = 6'b001000,
		ST_DRAIN     = 6'b010000,
		ST_BLANK     = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [CW-1:0]    cursor_q, cursor_d;
	logic [COLW-1:0]  col_q, col_d;
	logic [CW-1:0]    ptr_q, ptr_d;
	logic [7:0]       attr_q;
	logic             copy_wr_s1, copy_wr_d;
	logic [CW-1:0]    copy_addr_s1;
	logic             ram_we;
	logic [CW-1:0]    ram_waddr;
	logic [15:0]      ram_wdata;
	logic [CW-1:0]    ram_raddr;
	logic [15:0]      ram_rdata;
	logic             start;
	logic [CW-1:0]    back_pos;
	logic [WIDE_W-1:0] set_pos;
	logic [WIDE_W-1:0] cursor_wide;

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy        = (state_q == ST_INIT);
	assign start       = (state_q == ST_IDLE) && !cmd_empty && !res_full;
	assign back_pos    = (cursor_q == '0) ? '0 : cursor_q - 1'b1;
	assign set_pos     = WIDE_W'(cmd.row_index) * WIDE_W'(COLUMNS) + WIDE_W'(cmd.column);
	assign cursor_wide = WIDE_W'(cursor_d);

	always_comb begin
		state_d   = state_q;
		cursor_d  = cursor_q;
		col_d     = col_q;
		ptr_d     = ptr_q;
		copy_wr_d = 1'b0;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		ram_we    = copy_wr_s1;
		ram_waddr = copy_addr_s1;
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q + CW'(COLUMNS);
		res.position_error = 1'b0;
		res.read_char      = '0;
		res.read_attr      = '0;

		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = '0;
				ptr_d     = ptr_q + 1'b1;
				if (ptr_q == CW'(CELL_COUNT - 1)) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd_pop  = 1'b1;
					res_push = 1'b1;
					case (cmd.op)
						OP_PUT: begin
							ram_we    = 1'b1;
							ram_waddr = cursor_q;
							ram_wdata = {attr_q, cmd.char_code};
							if (cursor_q == CW'(CELL_COUNT - 1)) begin
								res_push = 1'b0;
								cursor_d = CW'(BOTTOM);
								col_d    = '0;
								ptr_d    = '0;
								state_d  = ST_COPY;
							end else begin
								cursor_d = cursor_q + 1'b1;
								col_d    = (col_q == COLW'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
							end
						end
						OP_NEWLINE: begin
							col_d = '0;
							if (cursor_q >= CW'(BOTTOM)) begin
								res_push = 1'b0;
								cursor_d = CW'(BOTTOM);
								ptr_d    = '0;
								state_d  = ST_COPY;
							end else begin
								cursor_d = cursor_q - CW'(col_q) + CW'(COLUMNS);
							end
						end
						OP_BACKSPACE: begin
							cursor_d  = back_pos;
							ram_we    = 1'b1;
							ram_waddr = back_pos;
							ram_wdata = {attr_q, BLANK_CHAR};
							if (cursor_q != '0) begin
								col_d = (col_q == '0) ? COLW'(COLUMNS - 1) : col_q - 1'b1;
							end
						end
						OP_CLEAR: begin
							res_push = 1'b0;
							cursor_d = '0;
							col_d    = '0;
							ptr_d    = '0;
							state_d  = ST_BLANK;
						end
						OP_SET_POS: begin
							cursor_d = CW'(set_pos);
							col_d    = COLW'(cmd.column);
						end
						OP_SET_POS_ERR: begin
							res.position_error = 1'b1;
						end
						OP_READ: begin
							res_push  = 1'b0;
							ram_raddr = CW'(cmd.cell_index);
							state_d   = ST_READ_WAIT;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ_WAIT: begin
				res_push      = 1'b1;
				res.read_char = ram_rdata[7:0];
				res.read_attr = ram_rdata[15:8];
				state_d       = ST_IDLE;
			end
			ST_COPY: begin
				copy_wr_d = 1'b1;
				ptr_d     = ptr_q + 1'b1;
				if (ptr_q == CW'(BOTTOM - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				ptr_d   = CW'(BOTTOM);
				state_d = ST_BLANK;
			end
			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = {attr_q, BLANK_CHAR};
				ptr_d     = ptr_q + 1'b1;
				if (ptr_q == CW'(CELL_COUNT - 1)) begin
					ptr_d    = '0;
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		res.cursor = cursor_wide[CURSOR_W-1:0];
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cursor_q   <= '0;
			col_q      <= '0;
			ptr_q      <= '0;
			copy_wr_s1 <= 1'b0;
			attr_q     <= ATTR_RESET;
		end else begin
			state_q    <= state_d;
			cursor_q   <= cursor_d;
			col_q      <= col_d;
			ptr_q      <= ptr_d;
			copy_wr_s1 <= copy_wr_d;
			if (cfg_we) begin
				attr_q <= cfg_data;
			end
		end
	end

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (int'(cursor_q) < CELL_COUNT))
		else $error("Cursor left the cell store.");

	a_copy_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		copy_wr_s1 |-> $past(state_q == ST_COPY))
		else $error("Scroll copy write without a preceding read.");

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("Result pushed into a full queue.");

	a_read_undisturbed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ_WAIT) |-> !ram_we)
		else $error("Cell store written while a cell read completes.");

endmodule

// ----- hdl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Keeps a store of character and attribute cells with a cursor, and takes
// put, backspace, clear, set-position and read-cell items.
// ----------------------------------------------------------------------------
// After reset the block clears its COLUMNS*ROWS cell store, one cell per
// cycle, and holds full high until that pass is done; attribute writes are
// taken during it. Items pass a registered intake stage and a short command
// queue to the engine, which owns the single write port of the cell store.
// A put, backspace or set-position item is done in the engine's idle state;
// a cell read waits in a further state for the registered read data. The
// engine starts an item only while the result queue has room. A put on the
// last cell or a newline on the bottom row scrolls the screen: the row copy
// reads and writes one cell a cycle, then the bottom row is blanked one cell
// a cycle. A clear blanks every cell. Each item gives one result, in order.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS     = DEF_COLUMNS,
	parameter int ROWS        = DEF_ROWS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  item_t      item,
	output logic       empty,
	input  logic       pop,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(result_t);

	logic             busy;
	logic             front_push;
	cmd_t             front_cmd;
	logic             cmd_full;
	logic             cmd_empty;
	logic             cmd_pop;
	logic [CMD_W-1:0] cmd_vec;
	cmd_t             cmd;
	logic             res_full;
	logic             res_push;
	result_t          res;
	logic [RES_W-1:0] res_vec;

	assign cfg_ready = 1'b1;
	assign cmd       = cmd_t'(cmd_vec);
	assign result    = result_t'(res_vec);

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.busy    (busy),
		.cmd_push(front_push),
		.cmd     (front_cmd),
		.cmd_full(cmd_full)
	);

	tcw_queue #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (front_push),
		.wdata (front_cmd),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_vec),
		.empty (cmd_empty)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.busy     (busy),
		.cmd_empty(cmd_empty),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	tcw_queue #(
		.WIDTH(RES_W),
		.DEPTH(QUEUE_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_vec),
		.empty (empty)
	);

endmodule
